FILE: rtl/rtde_pkg.sv
// rtde_pkg: types and constants for the runaway tail density evaluator
// no dependencies; used by runaway_tail_density_eval

package rtde_pkg;

    typedef enum logic [1:0] {
        CFG_FIELD  = 2'd0,
        CFG_CHARGE = 2'd1,
        CFG_PMAX   = 2'd2,
        CFG_WIDTH  = 2'd3
    } t_cfg_idx;

    localparam logic [31:0] ONE_Q16   = 32'h0001_0000;
    localparam logic [63:0] ONE_Q60   = 64'h1000_0000_0000_0000;
    localparam logic [31:0] PITCH_ONE = 32'h4000_0000;
    localparam logic [39:0] CAP_T     = 40'h80_0000_0000;
    localparam logic [38:0] CAP_X     = 39'h40_0000_0000;
    localparam logic [32:0] LOG2E_Q32 = 33'd6196328019;
    localparam logic [31:0] LN2_Q32   = 32'd2977044472;
    localparam logic [39:0] Y_OFFSET  = 40'h80_0000_0000;

    typedef struct packed {
        logic        inv;
        logic        gneg;
        logic        ce;
        logic [63:0] prod;
        logic [63:0] dp;
    } t_sb1;

    typedef struct packed {
        logic               inv;
        logic signed [8:0]  k;
        logic [63:0]        prod;
    } t_sb2;

    typedef struct packed {
        logic               inv;
        logic signed [9:0]  e;
    } t_sb3;

    // ceil(2^36 / n), exact floor division of 32-bit values by n
    function automatic logic [35:0] div_magic(input int n);
        logic [35:0] m;
        begin
            case (n)
                2:       m = 36'd34359738368;
                3:       m = 36'd22906492246;
                4:       m = 36'd17179869184;
                5:       m = 36'd13743895348;
                6:       m = 36'd11453246123;
                7:       m = 36'd9817068106;
                8:       m = 36'd8589934592;
                9:       m = 36'd7635497416;
                10:      m = 36'd6871947674;
                11:      m = 36'd6247225158;
                12:      m = 36'd5726623062;
                13:      m = 36'd5286113596;
                default: m = 36'd0;
            endcase
            return m;
        end
    endfunction

endpackage

FILE: rtl/rtde_div_pipe.sv
// rtde_div_pipe: pipelined restoring divider, one quotient bit per stage
// no dependencies; instantiated by runaway_tail_density_eval

module rtde_div_pipe #(
    parameter int DEN_W = 32,
    parameter int STEPS = 64
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [DEN_W-1:0] i_rem,
    input  logic [STEPS-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic [STEPS-1:0] o_quo
);

    logic [DEN_W-1:0] r_rem [STEPS];
    logic [DEN_W-1:0] r_den [STEPS];
    logic [STEPS-1:0] r_num [STEPS];
    logic [STEPS-1:0] r_quo [STEPS];

    for (genvar j = 0; j < STEPS; j++) begin : g_step
        logic [DEN_W-1:0] rem_in;
        logic [DEN_W-1:0] den_in;
        logic [STEPS-1:0] num_in;
        logic [STEPS-1:0] quo_in;
        logic [DEN_W:0]   shl;
        logic             take;

        if (j == 0) begin : g_first
            assign rem_in = i_rem;
            assign den_in = i_den;
            assign num_in = i_num;
            assign quo_in = '0;
        end else begin : g_next
            assign rem_in = r_rem[j-1];
            assign den_in = r_den[j-1];
            assign num_in = r_num[j-1];
            assign quo_in = r_quo[j-1];
        end

        assign shl  = {rem_in, num_in[STEPS-1]};
        assign take = shl >= {1'b0, den_in};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[j] <= take ? DEN_W'(shl - {1'b0, den_in}) : shl[DEN_W-1:0];
                r_den[j] <= den_in;
                r_num[j] <= num_in << 1;
                r_quo[j] <= {quo_in[STEPS-2:0], take};
            end
        end
    end

    assign o_quo = r_quo[STEPS-1];

endmodule

FILE: rtl/runaway_tail_density_eval.sv
// runaway_tail_density_eval: pipelined runaway-electron tail density evaluator
// depends on rtde_pkg and rtde_div_pipe
//
// channel  dir  handshake                     payload (lowest bits first)
// s_axis   in   s_axis_tvalid / tready        tdata: momentum, pitch
// m_axis   out  m_axis_tvalid / tready        tdata: density; tuser: saturated, invalid
// cfg      in   i_cfg_we                      i_cfg_idx, i_cfg_data
//
// one word per cycle while s_axis_tready is high; the path runs through 64-stage restoring dividers (two in series),
// the 13-term exp series (two multiply stages per term) and the normalize steps
// after reset and after each register write the coefficient divider runs,
// and s_axis_tready is low while it does
// a stall on m_axis holds the whole pipeline in place

module runaway_tail_density_eval (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // momentum[31:0], pitch[63:32]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // density[31:0]
    output logic [1:0]  m_axis_tuser,   // saturated[0], invalid[1]
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data
);

    localparam int DIV_STEPS = 64;
    localparam int SER_TERMS = 13;
    localparam int N_ITER    = SER_TERMS - 1;
    localparam int NRM_STEPS = 6;
    localparam int SBM_LEN   = 2 * N_ITER + 2;
    localparam int LAT       = 3 + DIV_STEPS + 7 + 2 * N_ITER + 1 + NRM_STEPS + DIV_STEPS + 1;

    // configuration and coefficient divider
    logic [31:0] r_field, r_charge, r_pmax, r_width;
    logic        r_dstart, r_dbusy;
    logic [5:0]  r_dcnt;
    logic [63:0] r_dnum;
    logic [32:0] r_drem, r_dden;
    logic [47:0] r_dq, r_coef_d;
    logic [33:0] w_dshl;
    logic        w_dtake;

    assign w_dshl  = {r_drem, r_dnum[63]};
    assign w_dtake = w_dshl >= {1'b0, r_dden};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_field  <= '0;
            r_charge <= rtde_pkg::ONE_Q16;
            r_pmax   <= '0;
            r_width  <= '0;
            r_dstart <= 1'b1;
            r_dbusy  <= 1'b0;
            r_dcnt   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                rtde_pkg::CFG_FIELD:  r_field  <= i_cfg_data;
                rtde_pkg::CFG_CHARGE: r_charge <= i_cfg_data;
                rtde_pkg::CFG_PMAX:   r_pmax   <= i_cfg_data;
                rtde_pkg::CFG_WIDTH:  r_width  <= i_cfg_data;
                default: ;
            endcase
            r_dstart <= 1'b1;
        end else if (r_dstart) begin
            r_dstart <= 1'b0;
            r_dbusy  <= 1'b1;
            r_dcnt   <= '0;
        end else if (r_dbusy) begin
            r_dcnt <= r_dcnt + 6'd1;
            if (r_dcnt == 6'(DIV_STEPS - 1)) begin
                r_dbusy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_dstart) begin
            r_dnum <= {({1'b0, r_field} + {1'b0, rtde_pkg::ONE_Q16}), 31'b0};
            r_dden <= {1'b0, r_charge} + {1'b0, rtde_pkg::ONE_Q16};
            r_drem <= '0;
            r_dq   <= '0;
        end else if (r_dbusy) begin
            r_dnum <= r_dnum << 1;
            r_drem <= w_dtake ? 33'(w_dshl - {1'b0, r_dden}) : w_dshl[32:0];
            r_dq   <= {r_dq[46:0], w_dtake};
            if (r_dcnt == 6'(DIV_STEPS - 1)) begin
                r_coef_d <= {r_dq[46:0], w_dtake};
            end
        end
    end

    // pipeline control
    logic [LAT-1:0] r_vld;
    logic           w_adv;
    logic           w_acc;

    assign w_adv         = !r_vld[LAT-1] || m_axis_tready;
    assign s_axis_tready = w_adv && !(r_dstart || r_dbusy);
    assign w_acc         = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[LAT-2:0], w_acc};
        end
    end

    // front stages
    logic [31:0] w_xw, w_abs;
    assign w_xw  = s_axis_tdata[63:32];
    assign w_abs = w_xw[31] ? (~w_xw + 32'd1) : w_xw;

    logic [31:0] r0_p, r0_a;
    logic        r0_inv;
    logic [63:0] r1_a2, r1_prod, r1_dq0;
    logic [47:0] r1_dq1;
    logic [31:0] r1_a, r1_d;
    logic        r1_ce, r1_gneg, r1_inv;
    logic [79:0] w_dpsum;
    logic [63:0] r2_gn;
    logic [31:0] r2_a, r2_d;
    rtde_pkg::t_sb1 r2_sb;

    assign w_dpsum = {r1_dq1, 32'b0} + {16'b0, r1_dq0};

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r0_p    <= s_axis_tdata[31:0];
            r0_a    <= w_abs;
            r0_inv  <= (s_axis_tdata[31:0] == '0) || (w_xw == '0);

            r1_a2   <= 64'(r0_a) * 64'(r0_a);
            r1_prod <= 64'(r0_p) * 64'(r0_a);
            r1_dq0  <= 64'(r_coef_d[31:0]) * 64'(r0_p);
            r1_dq1  <= 48'(r_coef_d[47:32]) * 48'(r0_p);
            r1_ce   <= (r_width != '0) && (r0_p >= r_pmax);
            r1_d    <= r0_p - r_pmax;
            r1_gneg <= r0_a > rtde_pkg::PITCH_ONE;
            r1_a    <= r0_a;
            r1_inv  <= r0_inv;

            r2_gn   <= r1_gneg ? ((r1_a2 - rtde_pkg::ONE_Q60) << 2)
                               : ((rtde_pkg::ONE_Q60 - r1_a2) << 2);
            r2_a    <= r1_a;
            r2_d    <= r1_d;
            r2_sb   <= '{inv: r1_inv, gneg: r1_gneg, ce: r1_ce,
                         prod: r1_prod, dp: w_dpsum[79:16]};
        end
    end

    // pitch factor and cut-off dividers
    logic [63:0] w_g, w_del;
    rtde_pkg::t_sb1 r_sb1 [DIV_STEPS];

    rtde_div_pipe #(.DEN_W(32), .STEPS(DIV_STEPS)) u_div_g (
        .i_clk (i_clk),
        .i_en  (w_adv),
        .i_rem (32'b0),
        .i_num (r2_gn),
        .i_den (r2_a),
        .o_quo (w_g)
    );

    rtde_div_pipe #(.DEN_W(32), .STEPS(DIV_STEPS)) u_div_c (
        .i_clk (i_clk),
        .i_en  (w_adv),
        .i_rem (32'b0),
        .i_num ({r2_d, 32'b0}),
        .i_den (r_width),
        .o_quo (w_del)
    );

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_sb1[0] <= r2_sb;
            for (int j = 1; j < DIV_STEPS; j++) begin
                r_sb1[j] <= r_sb1[j-1];
            end
        end
    end

    // exponent
    rtde_pkg::t_sb1 w_sbd;
    assign w_sbd = r_sb1[DIV_STEPS-1];

    logic [63:0]  r67_t00, r67_t01, r67_t10, r67_t11, r67_c00;
    logic [34:0]  r67_c01;
    logic [5:0]   r67_c11;
    logic         r67_cbig;
    rtde_pkg::t_sb1 r67_sb, r68_sb, r69_sb, r70_sb, r71_sb, r72_sb;
    logic [127:0] r68_tp;
    logic [69:0]  r68_cs;
    logic         r68_cbig;
    logic [39:0]  r69_t;
    logic [38:0]  r69_c;
    logic         r70_xpos;
    logic [38:0]  r70_xm;
    logic [64:0]  r71_ml;
    logic [39:0]  r71_mh;
    logic         r71_xpos;
    logic signed [8:0] r72_k;
    logic [31:0]  r72_r;

    logic signed [41:0] w_xs;
    logic               w_xpos;
    logic [38:0]        w_xm;
    logic [71:0]        w_magsum;
    logic [39:0]        w_mag, w_yo;

    always_comb begin
        w_xs = (r69_sb.gneg ? -$signed({2'b0, r69_t}) : $signed({2'b0, r69_t}))
             + $signed({3'b0, r69_c});
        if (w_xs > $signed({3'b0, rtde_pkg::CAP_X})) begin
            w_xm   = rtde_pkg::CAP_X;
            w_xpos = 1'b1;
        end else if (w_xs < -$signed({3'b0, rtde_pkg::CAP_X})) begin
            w_xm   = rtde_pkg::CAP_X;
            w_xpos = 1'b0;
        end else begin
            w_xm   = w_xs[41] ? 39'(-w_xs) : w_xs[38:0];
            w_xpos = (w_xs > 42'sd0);
        end
    end

    assign w_magsum = {7'b0, r71_ml} + {r71_mh, 32'b0};
    assign w_mag    = w_magsum[71:32];
    assign w_yo     = r71_xpos ? (rtde_pkg::Y_OFFSET - w_mag) : (rtde_pkg::Y_OFFSET + w_mag);

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r67_t00  <= 64'(w_g[31:0])  * 64'(w_sbd.dp[31:0]);
            r67_t01  <= 64'(w_g[31:0])  * 64'(w_sbd.dp[63:32]);
            r67_t10  <= 64'(w_g[63:32]) * 64'(w_sbd.dp[31:0]);
            r67_t11  <= 64'(w_g[63:32]) * 64'(w_sbd.dp[63:32]);
            r67_c00  <= 64'(w_del[31:0]) * 64'(w_del[31:0]);
            r67_c01  <= 35'(w_del[31:0]) * 35'(w_del[34:32]);
            r67_c11  <= 6'(w_del[34:32]) * 6'(w_del[34:32]);
            r67_cbig <= w_del[63:35] != '0;
            r67_sb   <= w_sbd;

            r68_tp   <= {64'b0, r67_t00} + {32'b0, r67_t01, 32'b0}
                      + {32'b0, r67_t10, 32'b0} + {r67_t11, 64'b0};
            r68_cs   <= {6'b0, r67_c00} + {2'b0, r67_c01, 33'b0} + {r67_c11, 64'b0};
            r68_cbig <= r67_cbig;
            r68_sb   <= r67_sb;

            r69_t    <= (r68_tp[127:32] > 96'(rtde_pkg::CAP_T)) ? rtde_pkg::CAP_T
                                                                 : r68_tp[71:32];
            r69_c    <= !r68_sb.ce ? '0 : (r68_cbig ? rtde_pkg::CAP_X
                                                    : {1'b0, r68_cs[69:32]});
            r69_sb   <= r68_sb;

            r70_xpos <= w_xpos;
            r70_xm   <= w_xm;
            r70_sb   <= r69_sb;

            r71_ml   <= 65'(r70_xm[31:0]) * 65'(rtde_pkg::LOG2E_Q32);
            r71_mh   <= 40'(r70_xm[38:32]) * 40'(rtde_pkg::LOG2E_Q32);
            r71_xpos <= r70_xpos;
            r71_sb   <= r70_sb;

            r72_k    <= $signed({1'b0, w_yo[39:32]}) - 9'sd128;
            r72_r    <= w_yo[31:0];
            r72_sb   <= r71_sb;
        end
    end

    // exp series
    logic [63:0] w_zp;
    logic [31:0] r73_z, r73_term;
    logic [33:0] r73_macc;
    rtde_pkg::t_sb2 r_sbm [SBM_LEN];

    assign w_zp = 64'(r72_r) * 64'(rtde_pkg::LN2_Q32);

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r73_z    <= w_zp[63:32];
            r73_term <= w_zp[63:32];
            r73_macc <= 34'h1_0000_0000;
            r_sbm[0] <= '{inv: r72_sb.inv, k: r72_k, prod: r72_sb.prod};
            for (int j = 1; j < SBM_LEN; j++) begin
                r_sbm[j] <= r_sbm[j-1];
            end
        end
    end

    logic [31:0] r_ita_v [N_ITER];
    logic [31:0] r_ita_z [N_ITER];
    logic [33:0] r_ita_macc [N_ITER];
    logic [31:0] r_itb_term [N_ITER];
    logic [31:0] r_itb_z [N_ITER];
    logic [33:0] r_itb_macc [N_ITER];

    for (genvar i = 0; i < N_ITER; i++) begin : g_term
        localparam logic [35:0] MAGIC = rtde_pkg::div_magic(i + 2);
        logic [31:0] term_in, z_in;
        logic [33:0] macc_in;
        logic [63:0] vp;
        logic [67:0] tp;

        if (i == 0) begin : g_first
            assign term_in = r73_term;
            assign z_in    = r73_z;
            assign macc_in = r73_macc;
        end else begin : g_next
            assign term_in = r_itb_term[i-1];
            assign z_in    = r_itb_z[i-1];
            assign macc_in = r_itb_macc[i-1];
        end

        assign vp = 64'(term_in) * 64'(z_in);
        assign tp = 68'(r_ita_v[i]) * 68'(MAGIC);

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_ita_v[i]    <= vp[63:32];
                r_ita_z[i]    <= z_in;
                r_ita_macc[i] <= macc_in + 34'(term_in);
                r_itb_term[i] <= tp[67:36];
                r_itb_z[i]    <= r_ita_z[i];
                r_itb_macc[i] <= r_ita_macc[i];
            end
        end
    end

    logic [33:0] r98_m;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r98_m <= r_itb_macc[N_ITER-1] + 34'(r_itb_term[N_ITER-1]);
        end
    end

    // divisor normalize
    logic [63:0] r_nrm_v [NRM_STEPS];
    logic [5:0]  r_nrm_s [NRM_STEPS];
    logic [33:0] r_nrm_m [NRM_STEPS];
    logic        r_nrm_inv [NRM_STEPS];
    logic signed [8:0] r_nrm_k [NRM_STEPS];

    for (genvar j = 0; j < NRM_STEPS; j++) begin : g_nrm
        localparam int SH = 32 >> j;
        logic [63:0] v_in;
        logic [5:0]  s_in;
        logic [33:0] m_in;
        logic        inv_in;
        logic signed [8:0] k_in;
        logic        zero;

        if (j == 0) begin : g_first
            assign v_in   = r_sbm[SBM_LEN-1].prod;
            assign s_in   = '0;
            assign m_in   = r98_m;
            assign inv_in = r_sbm[SBM_LEN-1].inv;
            assign k_in   = r_sbm[SBM_LEN-1].k;
        end else begin : g_next
            assign v_in   = r_nrm_v[j-1];
            assign s_in   = r_nrm_s[j-1];
            assign m_in   = r_nrm_m[j-1];
            assign inv_in = r_nrm_inv[j-1];
            assign k_in   = r_nrm_k[j-1];
        end

        assign zero = v_in[62 -: SH] == '0;

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_nrm_v[j]   <= zero ? (v_in << SH) : v_in;
                r_nrm_s[j]   <= s_in + (zero ? 6'(SH) : 6'd0);
                r_nrm_m[j]   <= m_in;
                r_nrm_inv[j] <= inv_in;
                r_nrm_k[j]   <= k_in;
            end
        end
    end

    // mantissa over divisor
    logic [63:0] w_q;
    logic signed [9:0] w_e;
    rtde_pkg::t_sb3 r_sb3 [DIV_STEPS];

    assign w_e = $signed({r_nrm_k[NRM_STEPS-1][8], r_nrm_k[NRM_STEPS-1]}) + 10'sd38
               + $signed({4'b0, r_nrm_s[NRM_STEPS-1]});

    rtde_div_pipe #(.DEN_W(63), .STEPS(DIV_STEPS)) u_div_h (
        .i_clk (i_clk),
        .i_en  (w_adv),
        .i_rem ({29'b0, r_nrm_m[NRM_STEPS-1]}),
        .i_num ('0),
        .i_den (r_nrm_v[NRM_STEPS-1][62:0]),
        .o_quo (w_q)
    );

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_sb3[0] <= '{inv: r_nrm_inv[NRM_STEPS-1], e: w_e};
            for (int j = 1; j < DIV_STEPS; j++) begin
                r_sb3[j] <= r_sb3[j-1];
            end
        end
    end

    // scale and saturate
    rtde_pkg::t_sb3    w_sbo;
    logic signed [9:0] w_sh;
    logic [63:0]       w_f;
    logic [31:0]       n_density;
    logic              n_sat;
    logic [31:0]       r_density;
    logic              r_sat, r_inv;

    assign w_sbo = r_sb3[DIV_STEPS-1];
    assign w_sh  = 10'sd64 - w_sbo.e;
    assign w_f   = w_q >> w_sh[5:0];

    always_comb begin
        n_density = '0;
        n_sat     = 1'b0;
        if (w_sbo.inv) begin
            n_density = '0;
        end else if (w_sbo.e >= 10'sd64) begin
            n_density = '1;
            n_sat     = 1'b1;
        end else if (w_sh >= 10'sd64) begin
            n_density = '0;
        end else if (w_f[63:32] != '0) begin
            n_density = '1;
            n_sat     = 1'b1;
        end else begin
            n_density = w_f[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_density <= n_density;
            r_sat     <= n_sat;
            r_inv     <= w_sbo.inv;
        end
    end

    assign m_axis_tdata = r_density;
    assign m_axis_tuser = {r_inv, r_sat};

endmodule
